>>> design/bbc_pkg.sv
// bbc_pkg: shared widths, register indexes, reset values and the configuration
// struct of the blob centroid block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

   localparam int MAX_DIM_DEF = 4096;

   localparam int PIX_W   = 8;
   localparam int DIM_W   = 13;
   localparam int CTR_W   = 12;
   localparam int THR_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;
   localparam logic [THR_W-1:0] THRESHOLD_RST    = 8'd127;
   localparam logic [CTR_W-1:0] DEFAULT_X_RST    = 12'd320;
   localparam logic [CTR_W-1:0] DEFAULT_Y_RST    = 12'd240;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_THRESHOLD    = 3'd2,
      REG_DEFAULT_X    = 3'd3,
      REG_DEFAULT_Y    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
      logic [THR_W-1:0] bright_threshold;
      logic [CTR_W-1:0] default_x;
      logic [CTR_W-1:0] default_y;
   } cfg_type;

endpackage

`default_nettype wire

>>> design/bbc_req_if.sv
// bbc_req_if: pixel channel, valid/ready with one grey pixel per transfer
// depends on bbc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bbc_req_if import bbc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

>>> design/bbc_rsp_if.sv
// bbc_rsp_if: result channel, valid/ready with one centre per transfer
// depends on bbc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bbc_rsp_if import bbc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CTR_W-1:0] center_x;
   logic [CTR_W-1:0] center_y;
   logic             found;

   modport source (output valid, output center_x, output center_y, output found, input ready);
   modport sink   (input valid, input center_x, input center_y, input found, output ready);
endinterface

`default_nettype wire

>>> design/bbc_front.sv
// bbc_front: pixel intake, raster position counters and per-frame sums;
// pushes the finished sums of a frame into the queue
// depends on bbc_pkg and bbc_req_if
`timescale 1ns / 1ps
`default_nettype none

module bbc_front import bbc_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF,
   localparam int POS_W = $clog2(MAX_DIM),
   localparam int CNT_W = 2 * POS_W + 1,
   localparam int SUM_W = 3 * POS_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   bbc_req_if.sink               req,
   output logic                  push_valid,
   input  wire logic             push_ready,
   output logic [SUM_W-1:0]      push_x,
   output logic [SUM_W-1:0]      push_y,
   output logic [CNT_W-1:0]      push_cnt
);

   localparam int LIM_A = $clog2(MAX_DIM + 1);
   localparam int LIM_W = (DIM_W > LIM_A) ? DIM_W : LIM_A;

   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [SUM_W-1:0] x_ff, x_in;
   logic [SUM_W-1:0] y_ff, y_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [LIM_W-1:0] width_lim, height_lim;
   logic [LIM_W-1:0] col_next, row_next;
   logic             col_end, row_end, frame_end, hit, take;
   logic [SUM_W-1:0] x_sum, y_sum;
   logic [CNT_W-1:0] cnt_sum;

   // zero acts as one, anything above the maximum as the maximum
   always_comb begin
      if (cfg.frame_width == '0) begin
         width_lim = LIM_W'(1);
      end else if (LIM_W'(cfg.frame_width) > LIM_W'(MAX_DIM)) begin
         width_lim = LIM_W'(MAX_DIM);
      end else begin
         width_lim = LIM_W'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         height_lim = LIM_W'(1);
      end else if (LIM_W'(cfg.frame_height) > LIM_W'(MAX_DIM)) begin
         height_lim = LIM_W'(MAX_DIM);
      end else begin
         height_lim = LIM_W'(cfg.frame_height);
      end
   end

   // at or beyond the last position, so a shrunk size ends at the next pixel
   assign col_next  = LIM_W'(col_ff) + LIM_W'(1);
   assign row_next  = LIM_W'(row_ff) + LIM_W'(1);
   assign col_end   = col_next >= width_lim;
   assign row_end   = row_next >= height_lim;
   assign frame_end = col_end && row_end;

   // only the last pixel of a frame needs room in the queue
   assign req.ready = push_ready || !frame_end;
   assign take      = req.valid && req.ready;
   assign hit       = req.pixel > cfg.bright_threshold;

   assign x_sum   = hit ? x_ff + SUM_W'(col_ff) : x_ff;
   assign y_sum   = hit ? y_ff + SUM_W'(row_ff) : y_ff;
   assign cnt_sum = hit ? cnt_ff + CNT_W'(1) : cnt_ff;

   assign push_valid = req.valid && frame_end;
   assign push_x     = x_sum;
   assign push_y     = y_sum;
   assign push_cnt   = cnt_sum;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      cnt_in = cnt_ff;
      if (take) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
            x_in   = '0;
            y_in   = '0;
            cnt_in = '0;
         end else begin
            x_in   = x_sum;
            y_in   = y_sum;
            cnt_in = cnt_sum;
            if (col_end) begin
               col_in = '0;
               row_in = POS_W'(row_next);
            end else begin
               col_in = POS_W'(col_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         x_ff   <= '0;
         y_ff   <= '0;
         cnt_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> design/bbc_queue.sv
// bbc_queue: two-entry queue of frame sums between intake and divider
// depends on bbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bbc_queue import bbc_pkg::*; #(
   parameter int WIDTH = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

>>> design/bbc_back.sv
// bbc_back: bit-serial divider for the two means and the result register
// depends on bbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bbc_back import bbc_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF,
   localparam int POS_W = $clog2(MAX_DIM),
   localparam int CNT_W = 2 * POS_W + 1,
   localparam int SUM_W = 3 * POS_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             pop_valid,
   output logic                  pop_ready,
   input  wire logic [SUM_W-1:0] pop_x,
   input  wire logic [SUM_W-1:0] pop_y,
   input  wire logic [CNT_W-1:0] pop_cnt,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [CTR_W-1:0]      rsp_center_x,
   output logic [CTR_W-1:0]      rsp_center_y,
   output logic                  rsp_found
);

   localparam int DW     = CNT_W + POS_W;
   localparam int STEP_W = $clog2(POS_W) + 1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_HOLD   = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [DW-1:0]     rem_x_ff, rem_x_in;
   logic [DW-1:0]     rem_y_ff, rem_y_in;
   logic [DW-1:0]     dsh_ff, dsh_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [POS_W-1:0]  qx_ff, qx_in;
   logic [POS_W-1:0]  qy_ff, qy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [CTR_W-1:0]  cx_ff, cx_in;
   logic [CTR_W-1:0]  cy_ff, cy_in;
   logic              found_ff, found_in;

   logic              bit_x, bit_y, found, out_free;
   logic [POS_W+CTR_W-1:0] qx_ext, qy_ext;

   assign bit_x    = rem_x_ff >= dsh_ff;
   assign bit_y    = rem_y_ff >= dsh_ff;
   assign found    = cnt_ff != '0;
   assign out_free = !valid_ff || rsp_ready;
   assign qx_ext   = (POS_W+CTR_W)'(qx_ff);
   assign qy_ext   = (POS_W+CTR_W)'(qy_ff);
   assign pop_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      dsh_in   = dsh_ff;
      cnt_in   = cnt_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_ready;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      found_in = found_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               rem_x_in = DW'(pop_x);
               rem_y_in = DW'(pop_y);
               // quotient is below the maximum size, so start at its top bit
               dsh_in   = DW'(pop_cnt) << (POS_W - 1);
               cnt_in   = pop_cnt;
               step_in  = STEP_W'(POS_W - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (bit_x) begin
               rem_x_in = rem_x_ff - dsh_ff;
            end
            if (bit_y) begin
               rem_y_in = rem_y_ff - dsh_ff;
            end
            qx_in  = POS_W'({qx_ff, bit_x});
            qy_in  = POS_W'({qy_ff, bit_y});
            dsh_in = dsh_ff >> 1;
            if (step_ff == '0) begin
               state_in = ST_HOLD;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               valid_in = 1'b1;
               found_in = found;
               cx_in    = found ? qx_ext[CTR_W-1:0] : cfg.default_x;
               cy_in    = found ? qy_ext[CTR_W-1:0] : cfg.default_y;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      dsh_ff   <= dsh_in;
      cnt_ff   <= cnt_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      step_ff  <= step_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      found_ff <= found_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_center_x = cx_ff;
   assign rsp_center_y = cy_ff;
   assign rsp_found    = found_ff;

endmodule

`default_nettype wire

>>> design/binary_blob_centroid.sv
// binary_blob_centroid: top level, configuration registers and the three stages
// depends on bbc_pkg, bbc_req_if, bbc_rsp_if, bbc_front, bbc_queue, bbc_back
`timescale 1ns / 1ps
`default_nettype none

// Centroid of the pixels brighter than a threshold in a grey frame sent in raster
// order. One pixel is taken per clock while the queue has room, since the last
// pixel of a frame is held back while the queue is full; the intake counts column
// and row against the configured frame size and keeps the sums. At the last pixel
// of a frame the sums go into a two-entry queue, and a bit-serial divider works
// out both means: the back stage picks up the entry, divides and then loads the
// result register, which waits while the last result has not yet been taken.
// A result is one transfer on rsp_out per frame, with found low and the default
// centre when no pixel qualified. Registers are written through csr_* and take
// effect at once; writes to unused indexes are dropped.

module binary_blob_centroid import bbc_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bbc_req_if.sink                    req_in,
   bbc_rsp_if.source                  rsp_out,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int CNT_W = 2 * POS_W + 1;
   localparam int SUM_W = 3 * POS_W;
   localparam int Q_W   = 2 * SUM_W + CNT_W;

   cfg_type          cfg_ff, cfg_in;

   logic             push_valid, push_ready;
   logic [SUM_W-1:0] push_x, push_y;
   logic [CNT_W-1:0] push_cnt;
   logic             pop_valid, pop_ready;
   logic [Q_W-1:0]   pop_data;
   logic [SUM_W-1:0] pop_x, pop_y;
   logic [CNT_W-1:0] pop_cnt;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:  cfg_in.frame_width      = csr_wdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height     = csr_wdata[DIM_W-1:0];
            REG_THRESHOLD:    cfg_in.bright_threshold = csr_wdata[THR_W-1:0];
            REG_DEFAULT_X:    cfg_in.default_x        = csr_wdata[CTR_W-1:0];
            REG_DEFAULT_Y:    cfg_in.default_y        = csr_wdata[CTR_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width      <= FRAME_WIDTH_RST;
         cfg_ff.frame_height     <= FRAME_HEIGHT_RST;
         cfg_ff.bright_threshold <= THRESHOLD_RST;
         cfg_ff.default_x        <= DEFAULT_X_RST;
         cfg_ff.default_y        <= DEFAULT_Y_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bbc_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_in),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_x     (push_x),
      .push_y     (push_y),
      .push_cnt   (push_cnt)
   );

   bbc_queue #(.WIDTH(Q_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_x, push_y, push_cnt}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_x, pop_y, pop_cnt} = pop_data;

   bbc_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_x        (pop_x),
      .pop_y        (pop_y),
      .pop_cnt      (pop_cnt),
      .rsp_valid    (rsp_out.valid),
      .rsp_ready    (rsp_out.ready),
      .rsp_center_x (rsp_out.center_x),
      .rsp_center_y (rsp_out.center_y),
      .rsp_found    (rsp_out.found)
   );

endmodule

`default_nettype wire

>>> tb/bbc_centroid_checker.sv
// bbc_centroid_checker: watches the pixel, result and register ports of the blob
// centroid block, predicts every centre and compares it with what comes out
// depends on bbc_pkg
`timescale 1ns / 1ps

module bbc_centroid_checker import bbc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [PIX_W-1:0]      req_pixel,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [CTR_W-1:0]      rsp_center_x,
   input  wire logic [CTR_W-1:0]      rsp_center_y,
   input  wire logic                  rsp_found,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending
);

   typedef struct packed {
      logic [CTR_W-1:0] cx;
      logic [CTR_W-1:0] cy;
      logic             found;
   } centre_type;

   centre_type  centre_q[$];
   cfg_type     regs;
   int unsigned col_pos;
   int unsigned row_pos;
   logic [35:0] x_sum;
   logic [35:0] y_sum;
   logic [24:0] hits;

   function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
   endfunction

   task automatic tally_pixel(input logic [PIX_W-1:0] pix);
      centre_type  c;
      int unsigned w;
      int unsigned h;
      w = eff_dim(regs.frame_width);
      h = eff_dim(regs.frame_height);
      if (pix > regs.bright_threshold) begin
         x_sum += col_pos;
         y_sum += row_pos;
         hits  += 1;
      end
      // at or beyond the last column ends the row, so a shrunk size ends it at once
      if (col_pos + 1 < w) begin
         col_pos++;
      end else begin
         col_pos = 0;
         if (row_pos + 1 < h) begin
            row_pos++;
         end else begin
            if (hits != 0) begin
               c.cx    = CTR_W'(x_sum / hits);
               c.cy    = CTR_W'(y_sum / hits);
               c.found = 1'b1;
            end else begin
               c.cx    = regs.default_x;
               c.cy    = regs.default_y;
               c.found = 1'b0;
            end
            centre_q.push_back(c);
            row_pos = 0;
            x_sum   = '0;
            y_sum   = '0;
            hits    = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      centre_type c;
      if (reset) begin
         regs.frame_width      = FRAME_WIDTH_RST;
         regs.frame_height     = FRAME_HEIGHT_RST;
         regs.bright_threshold = THRESHOLD_RST;
         regs.default_x        = DEFAULT_X_RST;
         regs.default_y        = DEFAULT_Y_RST;
         col_pos    = 0;
         row_pos    = 0;
         x_sum      = '0;
         y_sum      = '0;
         hits       = '0;
         fail_count = 0;
         centre_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_FRAME_WIDTH:  regs.frame_width      = csr_wdata;
               REG_FRAME_HEIGHT: regs.frame_height     = csr_wdata;
               REG_THRESHOLD:    regs.bright_threshold = csr_wdata[THR_W-1:0];
               REG_DEFAULT_X:    regs.default_x        = csr_wdata[CTR_W-1:0];
               REG_DEFAULT_Y:    regs.default_y        = csr_wdata[CTR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) tally_pixel(req_pixel);
         if (rsp_valid && rsp_ready) begin
            if (centre_q.size() == 0) begin
               fail_count++;
               $display("%0t: centre transfer with none expected, actual x=%0d y=%0d found=%0d",
                        $time, rsp_center_x, rsp_center_y, rsp_found);
            end else begin
               c = centre_q.pop_front();
               if (rsp_center_x !== c.cx) begin
                  fail_count++;
                  $display("%0t: center_x mismatch, expected %0d, actual %0d",
                           $time, c.cx, rsp_center_x);
               end
               if (rsp_center_y !== c.cy) begin
                  fail_count++;
                  $display("%0t: center_y mismatch, expected %0d, actual %0d",
                           $time, c.cy, rsp_center_y);
               end
               if (rsp_found !== c.found) begin
                  fail_count++;
                  $display("%0t: found mismatch, expected %0d, actual %0d",
                           $time, c.found, rsp_found);
               end
            end
         end
      end
      pending = centre_q.size();
   end

endmodule

>>> tb/tb_binary_blob_centroid.sv
// tb_binary_blob_centroid: drives frames of grey pixels and register settings into
// the blob centroid block and reports the verdict of the checker beside it
// depends on bbc_pkg, bbc_req_if, bbc_rsp_if, binary_blob_centroid, bbc_centroid_checker
`timescale 1ns / 1ps

module tb_binary_blob_centroid;
   import bbc_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RANDOM_ITEMS = 1650;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE       = 40;
   localparam int LONG_HOLD    = 400;
   localparam int PHASE_CAP    = 300;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef enum int {FILL_NOISE, FILL_DARK, FILL_BRIGHT, FILL_BLOB, FILL_EDGE} fill_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;
   int                    cycle_count;
   bit                    no_idle;
   bit                    hold_go;
   bit                    tx_gaps;
   int unsigned           eff_w;
   int unsigned           eff_h;
   logic [THR_W-1:0]      thr_now;
   int unsigned           box_x0, box_x1, box_y0, box_y1;

   bbc_req_if req_bus ();
   bbc_rsp_if rsp_bus ();

   binary_blob_centroid dut (
      .clock     (clock),
      .reset     (reset),
      .req_in    (req_bus),
      .rsp_out   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bbc_centroid_checker centroid_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_ready    (req_bus.ready),
      .req_pixel    (req_bus.pixel),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_center_x (rsp_bus.center_x),
      .rsp_center_y (rsp_bus.center_y),
      .rsp_found    (rsp_bus.found),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: random stall bursts, quiet stretches and one long hold-off
   initial begin : receiver
      int burst;
      int seg;
      bit quiet;
      burst = 0;
      seg   = 0;
      quiet = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            if (seg == 0) begin
               seg   = $urandom_range(50, 300);
               quiet = ($urandom_range(0, 3) == 0);
            end
            seg--;
            if (burst == 0 && !no_idle && !quiet && $urandom_range(0, 7) == 0)
               burst = $urandom_range(1, 14);
            if (burst != 0) begin
               rsp_bus.ready <= 1'b0;
               burst--;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   task automatic push_pixel(input logic [PIX_W-1:0] pix);
      if (tx_gaps && !no_idle && $urandom_range(0, 9) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= pix;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // leaves csr_we high; the caller lowers it after its last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic [THR_W-1:0] thr,
                               input logic [CTR_W-1:0] dx, input logic [CTR_W-1:0] dy);
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_THRESHOLD, CSR_DATA_W'(thr));
      write_reg(REG_DEFAULT_X, CSR_DATA_W'(dx));
      write_reg(REG_DEFAULT_Y, CSR_DATA_W'(dy));
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                   CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
      eff_w   = (w == 0) ? 1 : ((w > MAX_DIM_DEF) ? MAX_DIM_DEF : w);
      eff_h   = (h == 0) ? 1 : ((h > MAX_DIM_DEF) ? MAX_DIM_DEF : h);
      thr_now = thr;
   endtask

   function automatic logic [PIX_W-1:0] make_pixel(input fill_kind_type kind,
                                                   input int unsigned col,
                                                   input int unsigned row);
      logic [PIX_W-1:0] dark;
      logic [PIX_W-1:0] bright;
      dark   = PIX_W'($urandom_range(0, thr_now));
      bright = (thr_now == 8'hFF) ? 8'hFF : PIX_W'($urandom_range(int'(thr_now) + 1, 255));
      case (kind)
         FILL_DARK:   return dark;
         FILL_BRIGHT: return bright;
         FILL_BLOB:
            return (col >= box_x0 && col <= box_x1 && row >= box_y0 && row <= box_y1) ?
                   bright : dark;
         FILL_EDGE: begin
            case ($urandom_range(0, 3))
               0:       return 8'h00;
               1:       return 8'hFF;
               2:       return thr_now;
               default: return thr_now + 8'd1;
            endcase
         end
         default:     return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_frames(input int frames);
      fill_kind_type kind;
      for (int f = 0; f < frames; f++) begin
         kind   = fill_kind_type'($urandom_range(FILL_NOISE, FILL_EDGE));
         box_x0 = $urandom_range(0, eff_w - 1);
         box_x1 = $urandom_range(box_x0, eff_w - 1);
         box_y0 = $urandom_range(0, eff_h - 1);
         box_y1 = $urandom_range(box_y0, eff_h - 1);
         for (int r = 0; r < eff_h; r++)
            for (int c = 0; c < eff_w; c++)
               push_pixel(make_pixel(kind, c, r));
      end
   endtask

   initial begin : stimulus
      int                    phase;
      int                    frames;
      int                    used;
      logic [DIM_W-1:0]      w, h;
      logic [THR_W-1:0]      thr;
      logic [CTR_W-1:0]      dx, dy;
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      tx_gaps       = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one-pixel frames: threshold and default centre extremes
      program_regs(13'd1, 13'd1, 8'd0, 12'd4095, 12'd0);
      push_pixel(8'd0);
      push_pixel(8'd1);
      push_pixel(8'd255);
      wait_idle();
      // a zero size acts as one
      program_regs(13'd0, 13'd0, 8'd255, 12'd0, 12'd4095);
      push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd128);
      wait_idle();

      // width shrunk mid-row: the row ends at the next pixel
      program_regs(13'd4, 13'd2, 8'd127, 12'd100, 12'd200);
      push_pixel(8'd200);
      push_pixel(8'd10);
      push_pixel(8'd200);
      wait_idle();
      write_reg(REG_FRAME_WIDTH, 13'd2);
      csr_we <= 1'b0;
      push_pixel(8'd200);
      push_pixel(8'd10);
      push_pixel(8'd200);
      wait_idle();

      // height shrunk below the current row: the frame ends at the next row end
      program_regs(13'd1, 13'd5, 8'd50, 12'd7, 12'd9);
      push_pixel(8'd51);
      push_pixel(8'd50);
      push_pixel(8'd255);
      push_pixel(8'd0);
      wait_idle();
      write_reg(REG_FRAME_HEIGHT, 13'd2);
      csr_we <= 1'b0;
      push_pixel(8'd99);
      wait_idle();

      phase = 0;
      used  = 0;
      while (used < RANDOM_ITEMS) begin
         thr = ($urandom_range(0, 5) == 0) ? 8'd0 :
               ($urandom_range(0, 4) == 0) ? 8'd255 : THR_W'($urandom);
         dx  = ($urandom_range(0, 3) == 0) ? 12'd0 :
               ($urandom_range(0, 2) == 0) ? 12'd4095 : CTR_W'($urandom);
         dy  = ($urandom_range(0, 3) == 0) ? 12'd4095 :
               ($urandom_range(0, 2) == 0) ? 12'd0 : CTR_W'($urandom);
         w = DIM_W'($urandom_range(1, 12));
         h = DIM_W'($urandom_range(1, 10));
         if ($urandom_range(0, 9) == 0) w = 13'd0;
         if ($urandom_range(0, 9) == 0) h = 13'd0;
         frames = $urandom_range(2, 12);
         if (phase == 1) begin
            w      = DIM_W'($urandom_range(1, 3));
            h      = DIM_W'($urandom_range(1, 2));
            frames = 30;
         end
         tx_gaps = ($urandom_range(0, 3) != 0);
         if (used > RANDOM_ITEMS * 4 / 5) no_idle = 1'b1;
         program_regs(w, h, thr, dx, dy);
         // short phases so the run always ends with some frames sent without idling
         if (frames * int'(eff_w * eff_h) > PHASE_CAP)
            frames = PHASE_CAP / int'(eff_w * eff_h);
         // many tiny frames against a stalled receiver fill the block up
         if (phase == 1) hold_go = 1'b1;
         send_frames(frames);
         used += frames * int'(eff_w * eff_h);
         wait_idle();
         phase++;
      end

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> filelist.f
design/bbc_pkg.sv
design/bbc_req_if.sv
design/bbc_rsp_if.sv
design/bbc_front.sv
design/bbc_queue.sv
design/bbc_back.sv
design/binary_blob_centroid.sv
tb/bbc_centroid_checker.sv
tb/tb_binary_blob_centroid.sv
